// ===== sv/ttv_pkg.sv =====
// ttv_pkg: shared types and constants for the triangle tangent vector unit
// no dependencies
package ttv_pkg;

    localparam int unsigned DET_EPS_RESET = 32'd4295;
    localparam logic signed [32:0] DIFF_MAX = 33'sd2147483647;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_MUL_D,
        ST_SUB,
        ST_NORM,
        ST_SQ,
        ST_SQRT,
        ST_DIV,
        ST_OUT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_corner;
        logic load_third;
        logic mul_a;
        logic mul_b;
        logic mul_c;
        logic mul_d;
        logic sub;
        logic norm_step;
        logic sq_step;
        logic sqrt_start;
        logic sqrt_step;
        logic div_start;
        logic div_step;
        logic out_load;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic norm_done;
        logic zero_vec;
        logic sq_done;
        logic sqrt_done;
        logic div_done;
    } status_t;

    function automatic logic signed [31:0] sat_diff(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        if (d > DIFF_MAX)
            return 32'sh7fffffff;
        else if (d < -DIFF_MAX)
            return -32'sh7fffffff;
        else
            return d[31:0];
    endfunction

endpackage

// ===== sv/ttv_if.sv =====
// ttv_if: valid/ready channel interfaces for corners, tangents and config
// depends on nothing
interface ttv_corner_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] tex_u;
    logic [31:0] tex_v;
    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface ttv_tangent_if;
    logic        valid;
    logic        ready;
    logic [15:0] tangent_x;
    logic [15:0] tangent_y;
    logic [15:0] tangent_z;
    logic        degenerate;
    modport source (output valid, tangent_x, tangent_y, tangent_z, degenerate,
                    input ready);
    modport sink (input valid, tangent_x, tangent_y, tangent_z, degenerate,
                  output ready);
endinterface

interface ttv_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== sv/triangle_tangent_vector_unit.sv =====
// Triangle tangent unit. Corners are taken one per handshake; the first two
// are held and the third starts a sequential computation that gives one
// unit tangent in Q1.14 and a degenerate flag. A third corner occupies the
// unit for four multiply steps, a subtract, a one-bit-per-cycle normalize
// shift, three squares, a 31-step square root and a 46-step three-lane
// divide; a zero-length tangent skips from the normalize shift to the output.
// A finished result sits in an output register while the next triangle's
// first two corners are accepted. det_epsilon is to be written only while
// idle; the unit itself does not enforce this.
module triangle_tangent_vector_unit (
    input logic           clk,
    input logic           rst_n,
    ttv_corner_if.sink    corner,
    ttv_tangent_if.source tangent,
    ttv_cfg_if.sink       cfg
);
    ttv_pkg::cmd_t    cmd;
    ttv_pkg::status_t sts;
    logic             corner_sel;
    logic [31:0]      det_eps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            det_eps_reg <= ttv_pkg::DET_EPS_RESET;
        else if (cfg.valid)
            det_eps_reg <= cfg.data;
    end
    assign cfg.ready = 1'b1;

    ttv_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (corner.valid),
        .in_ready   (corner.ready),
        .out_valid  (tangent.valid),
        .out_ready  (tangent.ready),
        .corner_sel (corner_sel),
        .cmd        (cmd),
        .sts        (sts)
    );

    ttv_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_x       (corner.pos_x),
        .in_y       (corner.pos_y),
        .in_z       (corner.pos_z),
        .in_u       (corner.tex_u),
        .in_v       (corner.tex_v),
        .corner_sel (corner_sel),
        .det_eps    (det_eps_reg),
        .res_x      (tangent.tangent_x),
        .res_y      (tangent.tangent_y),
        .res_z      (tangent.tangent_z),
        .res_degen  (tangent.degenerate)
    );
endmodule

// ===== sv/ttv_datapath.sv =====
// ttv_datapath: corner store, products, normalize shift, iterative sqrt and divide
// depends on ttv_pkg
module ttv_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  ttv_pkg::cmd_t    cmd,
    output ttv_pkg::status_t sts,
    input  logic [31:0]      in_x,
    input  logic [31:0]      in_y,
    input  logic [31:0]      in_z,
    input  logic [31:0]      in_u,
    input  logic [31:0]      in_v,
    input  logic             corner_sel,
    input  logic [31:0]      det_eps,
    output logic [15:0]      res_x,
    output logic [15:0]      res_y,
    output logic [15:0]      res_z,
    output logic             res_degen
);
    logic signed [31:0] p0_reg [3];
    logic signed [31:0] p1_reg [3];
    logic signed [31:0] u0_reg, v0_reg, u1_reg, v1_reg;
    logic signed [31:0] e1_reg [3];
    logic signed [31:0] e2_reg [3];
    logic signed [31:0] du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic signed [63:0] pa_reg [4];
    logic signed [63:0] pb_reg [4];
    logic signed [64:0] t_reg [3];
    logic               det_neg_reg, degen_reg;
    logic [63:0]        m_reg [3];
    logic [63:0]        mx;
    logic [61:0]        sq_sum_reg;
    logic [1:0]         sq_idx_reg;
    logic [32:0]        rem_reg;
    logic [30:0]        root_reg;
    logic [4:0]         sqrt_cnt_reg;
    logic [45:0]        num_reg [3];
    logic [30:0]        quo_reg [3];
    logic [5:0]         div_cnt_reg;
    logic [15:0]        rx_reg, ry_reg, rz_reg;
    logic               rd_reg;

    logic signed [31:0] mul_a_l, mul_a_r, mul_b_l, mul_b_r;
    logic signed [63:0] prod_a;
    logic signed [63:0] prod_b;
    logic signed [64:0] det_w;
    logic [64:0]        det_mag;

    always_ff @(posedge clk)
    begin
        if (cmd.load_corner)
        begin
            if (!corner_sel)
            begin
                p0_reg[0] <= in_x; p0_reg[1] <= in_y; p0_reg[2] <= in_z;
                u0_reg <= in_u; v0_reg <= in_v;
            end
            else
            begin
                p1_reg[0] <= in_x; p1_reg[1] <= in_y; p1_reg[2] <= in_z;
                u1_reg <= in_u; v1_reg <= in_v;
            end
        end
        if (cmd.load_third)
        begin
            for (int i = 0; i < 3; i++)
                e1_reg[i] <= ttv_pkg::sat_diff(p1_reg[i], p0_reg[i]);
            e2_reg[0] <= ttv_pkg::sat_diff(in_x, p0_reg[0]);
            e2_reg[1] <= ttv_pkg::sat_diff(in_y, p0_reg[1]);
            e2_reg[2] <= ttv_pkg::sat_diff(in_z, p0_reg[2]);
            du1_reg <= ttv_pkg::sat_diff(u1_reg, u0_reg);
            dv1_reg <= ttv_pkg::sat_diff(v1_reg, v0_reg);
            du2_reg <= ttv_pkg::sat_diff(in_u, u0_reg);
            dv2_reg <= ttv_pkg::sat_diff(in_v, v0_reg);
        end
    end

    // one 32x32 multiplier pair per step: (det terms), then tangent x, y, z
    always_comb
    begin
        mul_a_l = du1_reg;
        mul_a_r = dv2_reg;
        mul_b_l = du2_reg;
        mul_b_r = dv1_reg;
        if (cmd.mul_b)
        begin
            mul_a_l = dv2_reg; mul_a_r = e1_reg[0];
            mul_b_l = dv1_reg; mul_b_r = e2_reg[0];
        end
        else if (cmd.mul_c)
        begin
            mul_a_l = dv2_reg; mul_a_r = e1_reg[1];
            mul_b_l = dv1_reg; mul_b_r = e2_reg[1];
        end
        else if (cmd.mul_d)
        begin
            mul_a_l = dv2_reg; mul_a_r = e1_reg[2];
            mul_b_l = dv1_reg; mul_b_r = e2_reg[2];
        end
        prod_a = 64'(mul_a_l) * 64'(mul_a_r);
        prod_b = 64'(mul_b_l) * 64'(mul_b_r);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_a) begin pa_reg[0] <= prod_a; pb_reg[0] <= prod_b; end
        if (cmd.mul_b) begin pa_reg[1] <= prod_a; pb_reg[1] <= prod_b; end
        if (cmd.mul_c) begin pa_reg[2] <= prod_a; pb_reg[2] <= prod_b; end
        if (cmd.mul_d) begin pa_reg[3] <= prod_a; pb_reg[3] <= prod_b; end
    end

    assign det_w   = 65'(pa_reg[0]) - 65'(pb_reg[0]);
    assign det_mag = det_w[64] ? 65'(-det_w) : 65'(det_w);

    always_ff @(posedge clk)
    begin
        if (cmd.sub)
        begin
            degen_reg   <= det_mag < 65'(det_eps);
            det_neg_reg <= det_w[64];
            for (int i = 0; i < 3; i++)
            begin
                t_reg[i] <= 65'(pa_reg[i+1]) - 65'(pb_reg[i+1]);
                m_reg[i] <= (pa_reg[i+1] < pb_reg[i+1]) ?
                            64'(pb_reg[i+1] - pa_reg[i+1]) :
                            64'(pa_reg[i+1] - pb_reg[i+1]);
            end
        end
        else if (cmd.norm_step)
        begin
            // one bit of shift per cycle toward [2^29, 2^30)
            for (int i = 0; i < 3; i++)
                m_reg[i] <= (mx[63:30] != '0) ? (m_reg[i] >> 1) : (m_reg[i] << 1);
        end
    end

    always_comb
    begin
        mx = m_reg[0];
        if (m_reg[1] > mx) mx = m_reg[1];
        if (m_reg[2] > mx) mx = m_reg[2];
    end

    assign sts.norm_done = (mx[63:30] == '0) && mx[29];
    assign sts.zero_vec  = (mx == '0);

    // sum of squares, one square per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_idx_reg <= '0;
        else if (cmd.sq_step)
            sq_idx_reg <= (sq_idx_reg == 2'd2) ? 2'd0 : sq_idx_reg + 2'd1;
    end

    logic [29:0] sq_op;
    logic [59:0] sq_term;
    assign sq_op   = m_reg[sq_idx_reg][29:0];
    assign sq_term = sq_op * sq_op;

    // the sum is shifted out two bits per square root step
    always_ff @(posedge clk)
    begin
        if (cmd.sq_step)
            sq_sum_reg <= ((sq_idx_reg == 2'd0) ? 62'd0 : sq_sum_reg) + 62'(sq_term);
        else if (cmd.sqrt_step)
            sq_sum_reg <= {sq_sum_reg[59:0], 2'b00};
    end
    assign sts.sq_done = (sq_idx_reg == 2'd2);

    // restoring square root, one result bit per cycle
    logic [34:0] rem_sh;
    logic [35:0] trial;
    always_comb
    begin
        rem_sh = {rem_reg, sq_sum_reg[61:60]};
        trial  = {1'b0, rem_sh} - {3'd0, root_reg, 2'b01};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            rem_reg      <= '0;
            root_reg     <= '0;
            sqrt_cnt_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            if (!trial[35])
            begin
                rem_reg  <= trial[32:0];
                root_reg <= {root_reg[29:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[32:0];
                root_reg <= {root_reg[29:0], 1'b0};
            end
            sqrt_cnt_reg <= sqrt_cnt_reg + 5'd1;
        end
    end
    assign sts.sqrt_done = (sqrt_cnt_reg == 5'd31);

    // restoring divide of (m*16384 + L/2) by L, three lanes, one bit per cycle
    logic [45:0] dividend [3];
    logic [46:0] part_rem [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dividend[i] = 46'({m_reg[i][29:0], 14'd0}) + 46'(root_reg[30:1]);
            part_rem[i] = {num_reg[i], dividend[i][6'd45 - div_cnt_reg]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i] <= '0;
                quo_reg[i] <= '0;
            end
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (part_rem[i] >= 47'(root_reg))
                begin
                    num_reg[i] <= 46'(part_rem[i] - 47'(root_reg));
                    quo_reg[i] <= {quo_reg[i][29:0], 1'b1};
                end
                else
                begin
                    num_reg[i] <= part_rem[i][45:0];
                    quo_reg[i] <= {quo_reg[i][29:0], 1'b0};
                end
            end
            div_cnt_reg <= div_cnt_reg + 6'd1;
        end
    end
    assign sts.div_done = (div_cnt_reg == 6'd46);

    function automatic logic [15:0] signed_out(input logic [30:0] q, input logic neg);
        logic [15:0] mag;
        mag = (q > 31'd16384) ? 16'd16384 : q[15:0];
        return neg ? 16'(17'h10000 - 17'(mag)) : mag;
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rd_reg <= degen_reg;
            if (mx == '0)
            begin
                rx_reg <= '0; ry_reg <= '0; rz_reg <= '0;
            end
            else
            begin
                rx_reg <= signed_out(quo_reg[0], t_reg[0][64] != (!degen_reg && det_neg_reg));
                ry_reg <= signed_out(quo_reg[1], t_reg[1][64] != (!degen_reg && det_neg_reg));
                rz_reg <= signed_out(quo_reg[2], t_reg[2][64] != (!degen_reg && det_neg_reg));
            end
        end
    end

    assign res_x     = rx_reg;
    assign res_y     = ry_reg;
    assign res_z     = rz_reg;
    assign res_degen = rd_reg;
endmodule

// ===== sv/ttv_ctrl.sv =====
// ttv_ctrl: corner counting and sequencing of the tangent datapath
// depends on ttv_pkg
module ttv_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             corner_sel,
    output ttv_pkg::cmd_t    cmd,
    input  ttv_pkg::status_t sts
);
    ttv_pkg::state_t state_reg, state_next;
    logic [1:0]      count_reg, count_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ttv_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign corner_sel = count_reg[0];
    assign out_valid  = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            ttv_pkg::ST_IDLE:
            begin
                // the third corner waits until the previous result is taken
                in_ready = (count_reg != 2'd2) || !out_valid_reg;
                if (in_valid && in_ready)
                begin
                    if (count_reg == 2'd2)
                    begin
                        cmd.load_third = 1'b1;
                        count_next     = '0;
                        state_next     = ttv_pkg::ST_MUL_A;
                    end
                    else
                    begin
                        cmd.load_corner = 1'b1;
                        count_next      = count_reg + 2'd1;
                    end
                end
            end
            ttv_pkg::ST_MUL_A: begin cmd.mul_a = 1'b1; state_next = ttv_pkg::ST_MUL_B; end
            ttv_pkg::ST_MUL_B: begin cmd.mul_b = 1'b1; state_next = ttv_pkg::ST_MUL_C; end
            ttv_pkg::ST_MUL_C: begin cmd.mul_c = 1'b1; state_next = ttv_pkg::ST_MUL_D; end
            ttv_pkg::ST_MUL_D: begin cmd.mul_d = 1'b1; state_next = ttv_pkg::ST_SUB; end
            ttv_pkg::ST_SUB:   begin cmd.sub = 1'b1; state_next = ttv_pkg::ST_NORM; end
            ttv_pkg::ST_NORM:
            begin
                if (sts.zero_vec)
                    state_next = ttv_pkg::ST_OUT;
                else if (sts.norm_done)
                    state_next = ttv_pkg::ST_SQ;
                else
                    cmd.norm_step = 1'b1;
            end
            ttv_pkg::ST_SQ:
            begin
                cmd.sq_step = 1'b1;
                if (sts.sq_done)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ttv_pkg::ST_SQRT;
                end
            end
            ttv_pkg::ST_SQRT:
            begin
                if (sts.sqrt_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ttv_pkg::ST_DIV;
                end
                else
                    cmd.sqrt_step = 1'b1;
            end
            ttv_pkg::ST_DIV:
            begin
                if (sts.div_done)
                    state_next = ttv_pkg::ST_OUT;
                else
                    cmd.div_step = 1'b1;
            end
            ttv_pkg::ST_OUT:
            begin
                if (!out_valid_reg)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ttv_pkg::ST_IDLE;
                end
            end
            default: state_next = ttv_pkg::ST_IDLE;
        endcase
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3) else $error("corner count out of range");
    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ttv_pkg::ST_IDLE |-> !in_ready) else $error("ready while busy");
    a_out_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid) else $error("result not shown");
    a_third_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_third |=> state_reg == ttv_pkg::ST_MUL_A) else $error("no start");
endmodule
